[rtl/cptb_pkg.sv]
// ----------------------------------------------------------------------------
// cptb_pkg
// Shared types and constants for the cascaded prescaled timer bank.
// ----------------------------------------------------------------------------
`default_nettype none

package cptb_pkg;

   typedef enum logic [1:0] {
      OP_TICK    = 2'd0,
      OP_RELOAD  = 2'd1,
      OP_CONTROL = 2'd2,
      OP_READ    = 2'd3
   } op_type;

   // control byte layout
   localparam logic [7:0] CTRL_WRITABLE   = 8'hc7;
   localparam int         CTRL_CASCADE_BIT = 2;
   localparam int         CTRL_IRQ_BIT     = 6;
   localparam int         CTRL_START_BIT   = 7;

   localparam int PRESC_WIDTH = 10;

   // command broadcast to every cell in the chain
   typedef struct packed {
      op_type      op;
      logic [15:0] data;
      logic [15:0] mask;
   } cmd_type;

   // per-cell status handed back to the top level
   typedef struct packed {
      logic carry;
      logic irq;
   } cell_status_type;

   // prescaler divide ratio for a 2-bit select
   function automatic logic [PRESC_WIDTH:0] presc_div(input logic [1:0] sel);
      logic [PRESC_WIDTH:0] d;
      unique case (sel)
         2'd0:    d = 11'd1;
         2'd1:    d = 11'd64;
         2'd2:    d = 11'd256;
         default: d = 11'd1024;
      endcase
      return d;
   endfunction

endpackage

`default_nettype wire

[rtl/cptb_if.sv]
// ----------------------------------------------------------------------------
// cptb request / response channels
// Valid/ready channels carrying timer commands and their results.
// ----------------------------------------------------------------------------
`default_nettype none

interface cptb_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [1:0]  timer_index;
   logic [15:0] write_data;
   logic [15:0] write_mask;

   modport source (output valid, op, timer_index, write_data, write_mask, input ready);
   modport sink   (input valid, op, timer_index, write_data, write_mask, output ready);
endinterface

interface cptb_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] read_data;
   logic [3:0]  irq_raised;

   modport source (output valid, read_data, irq_raised, input ready);
   modport sink   (input valid, read_data, irq_raised, output ready);
endinterface

`default_nettype wire

[rtl/cptb_cell.sv]
// ----------------------------------------------------------------------------
// cptb_cell
// One timer channel: reload, counter, control byte and prescale phase.
// ----------------------------------------------------------------------------
`default_nettype none

module cptb_cell
   import cptb_pkg::*;
#(
   parameter int COUNT_WIDTH = 16,
   parameter bit FIRST_CELL  = 1'b0
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    accept,
   input  cmd_type                cmd,
   input  wire                    sel,
   input  wire                    carry_in,
   output cell_status_type        status,
   output logic [COUNT_WIDTH-1:0] count_value
);

   logic [COUNT_WIDTH-1:0] reload_ff,  reload_in;
   logic [COUNT_WIDTH-1:0] counter_ff, counter_in;
   logic [7:0]             ctrl_ff,    ctrl_in;
   logic [PRESC_WIDTH-1:0] presc_ff,   presc_in;

   logic [COUNT_WIDTH-1:0] wr_data, wr_mask;
   logic [7:0]             ctrl_mask;
   logic [PRESC_WIDTH:0]   presc_next;
   logic                   own_clock;
   logic                   inc;
   logic                   ovf;

   assign wr_data   = COUNT_WIDTH'(cmd.data);
   assign wr_mask   = COUNT_WIDTH'(cmd.mask);
   assign ctrl_mask = cmd.mask[7:0] & CTRL_WRITABLE;
   assign own_clock = FIRST_CELL || !ctrl_ff[CTRL_CASCADE_BIT];
   assign presc_next = {1'b0, presc_ff} + 1'b1;

   always_comb begin
      reload_in  = reload_ff;
      counter_in = counter_ff;
      ctrl_in    = ctrl_ff;
      presc_in   = presc_ff;
      inc        = 1'b0;
      ovf        = 1'b0;

      if (accept) begin
         unique case (cmd.op)
            OP_TICK: begin
               if (ctrl_ff[CTRL_START_BIT]) begin
                  if (own_clock) begin
                     if (presc_next >= presc_div(ctrl_ff[1:0])) begin
                        presc_in = '0;
                        inc      = 1'b1;
                     end else begin
                        presc_in = presc_next[PRESC_WIDTH-1:0];
                     end
                  end else begin
                     inc = carry_in;
                  end
               end
               ovf = inc && (&counter_ff);
               if (inc) begin
                  counter_in = ovf ? reload_ff : counter_ff + 1'b1;
               end
            end
            OP_RELOAD: begin
               if (sel) begin
                  reload_in = (reload_ff & ~wr_mask) | (wr_data & wr_mask);
               end
            end
            OP_CONTROL: begin
               if (sel) begin
                  ctrl_in  = (ctrl_ff & ~ctrl_mask) | (cmd.data[7:0] & ctrl_mask);
                  presc_in = '0;
                  // start edge loads the counter
                  if (ctrl_in[CTRL_START_BIT] && !ctrl_ff[CTRL_START_BIT]) begin
                     counter_in = reload_ff;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign status.carry = ovf;
   assign status.irq   = ovf && ctrl_ff[CTRL_IRQ_BIT];
   assign count_value  = counter_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         reload_ff  <= '0;
         counter_ff <= '0;
         ctrl_ff    <= '0;
         presc_ff   <= '0;
      end else begin
         reload_ff  <= reload_in;
         counter_ff <= counter_in;
         ctrl_ff    <= ctrl_in;
         presc_ff   <= presc_in;
      end
   end

endmodule

`default_nettype wire

[rtl/cascaded_prescaled_timer_bank.sv]
// A result beat leaves from the output register, waiting in the skid entry under a stall.
// Throughput: one request beat per cycle while the skid entry is empty; an overflow
//   carry ripples through all NUM_TIMERS cells in the same cycle: the critical path.
// A two-entry output stage (main + skid) absorbs one more request beat while rsp stalls.
// Reset (synchronous, active high) clears every channel and empties the output stage.
// ----------------------------------------------------------------------------
// cascaded_prescaled_timer_bank
// Bank of up-counting timers with prescalers and count-up cascade, driven by
// tick / reload-write / control-write / counter-read request beats.
// ----------------------------------------------------------------------------
`default_nettype none

module cascaded_prescaled_timer_bank
   import cptb_pkg::*;
#(
   parameter int NUM_TIMERS  = 4,
   parameter int COUNT_WIDTH = 16
) (
   input  wire        clock,
   input  wire        reset,
   cptb_req_if.sink   req_bus,
   cptb_rsp_if.source rsp_bus
);

   // ------------------------------------------------------------------
   // Request decode
   // ------------------------------------------------------------------
   logic    req_accept;
   logic    rsp_take;
   cmd_type cmd;
   logic    index_ok;

   logic rsp_valid_ff,  rsp_valid_in;
   logic skid_valid_ff, skid_valid_in;

   // request side only stalls once the skid entry is occupied
   assign req_bus.ready = !skid_valid_ff;
   assign req_accept    = req_bus.valid && req_bus.ready;
   assign rsp_take      = rsp_valid_ff && rsp_bus.ready;

   assign cmd.op   = op_type'(req_bus.op);
   assign cmd.data = req_bus.write_data;
   assign cmd.mask = req_bus.write_mask;

   // channels past the end of the bank ignore writes and read as zero
   assign index_ok = int'(req_bus.timer_index) < NUM_TIMERS;

   // ------------------------------------------------------------------
   // Chain of timer cells; carry[i] is the overflow of channel i-1
   // ------------------------------------------------------------------
   logic [NUM_TIMERS:0]    carry;
   logic [NUM_TIMERS-1:0]  irq_vec;
   logic [COUNT_WIDTH-1:0] counts [NUM_TIMERS];

   assign carry[0] = 1'b0;

   for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
      cell_status_type st;
      logic            hit;

      assign hit = index_ok && (int'(req_bus.timer_index) == i);

      cptb_cell #(
         .COUNT_WIDTH (COUNT_WIDTH),
         .FIRST_CELL  (i == 0)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .accept      (req_accept),
         .cmd         (cmd),
         .sel         (hit),
         .carry_in    (carry[i]),
         .status      (st),
         .count_value (counts[i])
      );

      assign carry[i+1] = st.carry;
      assign irq_vec[i] = st.irq;
   end

   // ------------------------------------------------------------------
   // Result beat: counter read (pre-update value) or tick IRQ bits
   // ------------------------------------------------------------------
   logic [15:0] rd_new;
   logic [3:0]  irq_new;

   // only an index inside the bank can match, so others read zero
   always_comb begin
      rd_new = '0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
         if (cmd.op == OP_READ && int'(req_bus.timer_index) == i) begin
            rd_new = 16'(counts[i]);
         end
      end
   end

   // irq_vec is only nonzero on tick beats; bits above 3 fall off
   assign irq_new = 4'(irq_vec);

   // ------------------------------------------------------------------
   // Output stage: main register plus one skid entry
   // ------------------------------------------------------------------
   logic [15:0] rsp_rd_ff,   rsp_rd_in;
   logic [3:0]  rsp_irq_ff,  rsp_irq_in;
   logic [15:0] skid_rd_ff,  skid_rd_in;
   logic [3:0]  skid_irq_ff, skid_irq_in;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      skid_valid_in = skid_valid_ff;
      rsp_rd_in     = rsp_rd_ff;
      rsp_irq_in    = rsp_irq_ff;
      skid_rd_in    = skid_rd_ff;
      skid_irq_in   = skid_irq_ff;

      priority if (skid_valid_ff) begin
         // no new beat can arrive; drain skid into main
         if (rsp_take) begin
            rsp_rd_in     = skid_rd_ff;
            rsp_irq_in    = skid_irq_ff;
            skid_valid_in = 1'b0;
         end
      end else if (req_accept) begin
         if (!rsp_valid_ff || rsp_take) begin
            rsp_valid_in = 1'b1;
            rsp_rd_in    = rd_new;
            rsp_irq_in   = irq_new;
         end else begin
            skid_valid_in = 1'b1;
            skid_rd_in    = rd_new;
            skid_irq_in   = irq_new;
         end
      end else if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_rd_ff   <= rsp_rd_in;
      rsp_irq_ff  <= rsp_irq_in;
      skid_rd_ff  <= skid_rd_in;
      skid_irq_ff <= skid_irq_in;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.read_data  = rsp_rd_ff;
   assign rsp_bus.irq_raised = rsp_irq_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   // skid entry is only ever filled behind a full main register
   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry valid while main register empty");

   // only tick beats can raise IRQ bits
   a_irq_only_on_tick: assert property (@(posedge clock) disable iff (reset)
      (req_accept && cmd.op != OP_TICK) |-> (irq_vec == '0))
      else $error("IRQ raised on a non-tick beat");

   // a beat accepted against a stalled full main register lands in skid
   a_stall_fills_skid: assert property (@(posedge clock) disable iff (reset)
      (req_accept && rsp_valid_ff && !rsp_bus.ready) |=> skid_valid_ff)
      else $error("beat accepted under stall did not reach skid entry");

endmodule

`default_nettype wire
